[hw/rtl/dwpi_pkg.sv]
// Shared types and constants for the dual-wheel PI speed controller.
// Holds the item structs, the sequencer states and the arithmetic widths.
// No dependencies.
`default_nettype none

package dwpi_pkg;

  // Configuration port.
  localparam int unsigned CfgW    = 16;
  localparam int unsigned CfgIdxW = 3;

  localparam logic [CfgIdxW-1:0] CFG_PROP_GAIN     = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_INV_INTEG     = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_SAMPLE_PERIOD = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_TRACK_FACTOR  = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_DRIVE_LIMIT   = 3'd4;

  localparam logic [CfgW-1:0] RST_PROP_GAIN     = 16'd525;
  localparam logic [CfgW-1:0] RST_INV_INTEG     = 16'd512;
  localparam logic [CfgW-1:0] RST_SAMPLE_PERIOD = 16'd200;
  localparam logic [CfgW-1:0] RST_TRACK_FACTOR  = 16'd1638;
  localparam logic [CfgW-1:0] RST_DRIVE_LIMIT   = 16'd64000;

  // Shared multiplier: signed 34 x signed 18.
  localparam int unsigned MulAW = 34;
  localparam int unsigned MulBW = 18;
  localparam int unsigned MulPW = MulAW + MulBW;

  // Divider by the millisecond scale: one base-65536 digit a cycle, each
  // digit found by reciprocal multiplication.
  localparam int unsigned DivW          = 64;
  localparam int unsigned DivRemW       = 10;
  localparam int unsigned DivDigitW     = 16;
  localparam int unsigned DivSteps      = DivW / DivDigitW;
  localparam int unsigned DivCntW       = $clog2(DivSteps);
  localparam int unsigned DivPartW      = DivRemW + DivDigitW;
  localparam int unsigned DivRecipW     = 29;
  localparam int unsigned DivRecipShift = 38;
  localparam int unsigned DivProdW      = DivPartW + DivRecipW;
  localparam logic [DivRemW:0] DivConst = 11'd1000;
  // floor(x / 1000) equals (x * DivRecip) >> 38 for every x below 2^32.
  localparam logic [DivRecipW-1:0] DivRecip = 29'd274877907;

  // Fixed-point shifts.
  localparam int unsigned TrackShift = 17;
  localparam int unsigned GainFrac   = 8;

  typedef struct packed {
    logic signed [15:0] lin_ref;
    logic signed [15:0] ang_ref;
    logic signed [15:0] meas_left;
    logic signed [15:0] meas_right;
    logic        [15:0] tick_ms;
  } in_item_t;

  typedef struct packed {
    logic signed [16:0] drive;
    logic               updated;
    logic               clamped;
  } out_item_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_HALF,
    S_SPLIT,
    S_EDT,
    S_INTEG,
    S_ILO,
    S_IHI,
    S_IACC,
    S_DIV,
    S_GLO,
    S_GHI,
    S_GACC,
    S_AVG
  } state_e;

endpackage

`default_nettype wire

[hw/rtl/dwpi_mul.sv]
// Shared registered multiplier of the PI controller datapath.
// Depends on dwpi_pkg for the operand widths.
`default_nettype none

module dwpi_mul
  import dwpi_pkg::*;
(
  input  logic                    clk_i,
  input  logic signed [MulAW-1:0] a_i,
  input  logic signed [MulBW-1:0] b_i,
  output logic signed [MulPW-1:0] p_o
);

  logic signed [MulPW-1:0] p_q;

  // One product per cycle, available the cycle after the operands.
  always_ff @(posedge clk_i) begin
    p_q <= MulPW'(a_i) * MulPW'(b_i);
  end

  assign p_o = p_q;

endmodule

`default_nettype wire

[hw/rtl/dwpi_div.sv]
// Unsigned divider by the constant 1000, one base-65536 digit a cycle by
// reciprocal multiplication. Depends on dwpi_pkg for widths and constants.
`default_nettype none

module dwpi_div
  import dwpi_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [DivW-1:0] dividend_i,
  output logic            busy_o,
  output logic            done_o,
  output logic [DivW-1:0] quotient_o
);

  logic               busy_q, busy_d;
  logic               done_q, done_d;
  logic [DivCntW-1:0] cnt_q, cnt_d;
  logic [DivW-1:0]    dvd_q, dvd_d;
  logic [DivRemW-1:0] rem_q, rem_d;

  always_comb begin : step
    logic [DivPartW-1:0]  part;
    logic [DivProdW-1:0]  prod;
    logic [DivDigitW-1:0] qd;
    logic [DivPartW-1:0]  back;
    // Long division in base 65536: the partial remainder joined with the
    // next digit stays below 2^26, where the reciprocal product is exact.
    // The dividend shifts out at the top while quotient digits shift in.
    part = {rem_q, dvd_q[DivW-1 -: DivDigitW]};
    prod = DivProdW'(part) * DivProdW'(DivRecip);
    qd   = prod[DivRecipShift +: DivDigitW];
    back = DivPartW'(qd) * DivPartW'(DivConst);

    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      dvd_d  = dividend_i;
      rem_d  = '0;
    end else if (busy_q) begin
      dvd_d = {dvd_q[DivW-DivDigitW-1:0], qd};
      rem_d = DivRemW'(part - back);
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == DivCntW'(DivSteps - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      rem_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
      rem_q  <= rem_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
  end

  assign busy_o     = busy_q;
  assign done_o     = done_q;
  assign quotient_o = dvd_q;

`ifndef SYNTH
  a_rem_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rem_q < DivConst[DivRemW-1:0])
    else $error("divider remainder out of range");

  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q)
    else $error("divider done held longer than one cycle");

  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q)
    else $error("divider started while busy");
`endif

endmodule

`default_nettype wire

[hw/rtl/dual_wheel_pi_speed_control.sv]
// When no PI update runs, the item passes the reference split straight to
// averaging; when one does, the right wheel and then the left are worked,
// each with a pass of the divide-by-1000 unit. The block takes the next
// item only in the idle state, after the result is registered; a stalled
// result holds the block in the averaging step. Reset (async, active
// low) clears integrators, drives, elapsed time and loads register defaults.
`default_nettype none

module dual_wheel_pi_speed_control
  import dwpi_pkg::*;
#(
  parameter int unsigned INTEG_WIDTH = 48
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  in_item_t           in_item_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output out_item_t          out_item_o,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_data_i
);

  // Width of the integrator add before it is saturated back.
  localparam int unsigned SumW = ((INTEG_WIDTH > MulPW) ? INTEG_WIDTH : MulPW) + 1;
  // Width of a joined pair of partial products.
  localparam int unsigned AccW = MulPW + 32;

  // Configuration registers.
  logic [CfgW-1:0] gain_q, inv_q, period_q, track_q, lim_q;

  // Sequencer and datapath state.
  state_e                        state_q, state_d;
  logic                          wheel_q, wheel_d;   // 0: right, 1: left
  in_item_t                      in_q, in_d;
  logic [31:0]                   since_q, since_d;
  logic [31:0]                   dt_q, dt_d;
  logic                          upd_q, upd_d;
  logic signed [17:0]            err_r_q, err_r_d, err_l_q, err_l_d;
  logic signed [MulPW-1:0]       lo_q, lo_d;
  logic                          neg_q, neg_d;
  logic signed [63:0]            sum_q, sum_d;
  logic signed [INTEG_WIDTH-1:0] integ_r_q, integ_r_d, integ_l_q, integ_l_d;
  logic signed [31:0]            drv_r_q, drv_r_d, drv_l_q, drv_l_d;
  out_item_t                     out_q, out_d;
  logic                          out_valid_q, out_valid_d;

  // Shared units.
  logic signed [MulAW-1:0] mul_a;
  logic signed [MulBW-1:0] mul_b;
  logic signed [MulPW-1:0] mul_p;
  logic                    div_start, div_busy, div_done;
  logic [DivW-1:0]         div_dividend, div_quot;

  // Helpers shared by the sequencer steps.
  logic                          due, out_free;
  logic signed [17:0]            err_sel;
  logic signed [INTEG_WIDTH-1:0] integ_sel;
  logic signed [63:0]            integ_ext;

  // Joins a high and a low partial product: hi * 2^32 + lo.
  function automatic logic signed [AccW-1:0] join_parts(
    input logic signed [MulPW-1:0] hi,
    input logic signed [MulPW-1:0] lo
  );
    logic signed [AccW-1:0] hs;
    logic signed [AccW-1:0] ls;
    hs = AccW'(hi) <<< 32;
    ls = AccW'(lo);
    return hs + ls;
  endfunction

  function automatic logic signed [63:0] sat64(input logic signed [AccW-1:0] v);
    logic signed [63:0] r;
    if (v[AccW-1:63] != {(AccW - 63){v[AccW-1]}}) begin
      r = v[AccW-1] ? {1'b1, 63'b0} : {1'b0, {63{1'b1}}};
    end else begin
      r = v[63:0];
    end
    return r;
  endfunction

  function automatic logic signed [31:0] sat32_shifted(input logic signed [AccW-1:0] v);
    logic signed [AccW-1:0] t;
    logic signed [31:0]     r;
    t = v >>> GainFrac;
    if (t[AccW-1:31] != {(AccW - 31){t[AccW-1]}}) begin
      r = t[AccW-1] ? {1'b1, 31'b0} : {1'b0, {31{1'b1}}};
    end else begin
      r = t[31:0];
    end
    return r;
  endfunction

  dwpi_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  dwpi_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .quotient_o (div_quot)
  );

  assign due       = since_q > {16'b0, period_q};
  assign out_free  = !out_valid_q || out_ready_i;
  assign err_sel   = wheel_q ? err_l_q : err_r_q;
  assign integ_sel = wheel_q ? integ_l_q : integ_r_q;
  assign integ_ext = 64'(integ_sel);

  // Configuration writes; unknown indexes are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q   <= RST_PROP_GAIN;
      inv_q    <= RST_INV_INTEG;
      period_q <= RST_SAMPLE_PERIOD;
      track_q  <= RST_TRACK_FACTOR;
      lim_q    <= RST_DRIVE_LIMIT;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_PROP_GAIN:     gain_q   <= cfg_data_i;
        CFG_INV_INTEG:     inv_q    <= cfg_data_i;
        CFG_SAMPLE_PERIOD: period_q <= cfg_data_i;
        CFG_TRACK_FACTOR:  track_q  <= cfg_data_i;
        CFG_DRIVE_LIMIT:   lim_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Sequencer: splits the reference; when due, per wheel runs err*dt, the
  // integrator, the two partial products of integ/Ti, the divide by 1000
  // and the two partial products of the gain, then averages the drives.
  always_comb begin : next_state
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (in_valid_i) state_d = S_HALF;
      S_HALF:  state_d = S_SPLIT;
      S_SPLIT: state_d = due ? S_EDT : S_AVG;
      S_EDT:   state_d = S_INTEG;
      S_INTEG: state_d = S_ILO;
      S_ILO:   state_d = S_IHI;
      S_IHI:   state_d = S_IACC;
      S_IACC:  state_d = S_DIV;
      S_DIV:   if (div_done) state_d = S_GLO;
      S_GLO:   state_d = S_GHI;
      S_GHI:   state_d = S_GACC;
      S_GACC:  state_d = wheel_q ? S_AVG : S_EDT;
      S_AVG:   if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin : datapath
    logic [32:0]              since_sum;
    logic signed [15:0]       half;
    logic signed [SumW-1:0]   isum;
    logic signed [AccW-1:0]   acc;
    logic signed [63:0]       x;
    logic signed [63:0]       qs;
    logic signed [32:0]       dsum;
    logic signed [32:0]       avg;
    logic signed [32:0]       lim_ext;

    since_sum = {1'b0, since_q} + 33'(in_item_i.tick_ms);
    half      = mul_p[TrackShift+15:TrackShift];
    isum      = SumW'(integ_sel) + SumW'(mul_p);
    acc       = join_parts(mul_p, lo_q);
    x         = sat64(acc);
    qs        = neg_q ? -signed'(div_quot) : signed'(div_quot);
    dsum      = 33'(drv_l_q) + 33'(drv_r_q);
    avg       = dsum >>> 1;
    lim_ext   = signed'({17'b0, lim_q});

    in_d         = in_q;
    wheel_d      = wheel_q;
    since_d      = since_q;
    dt_d         = dt_q;
    upd_d        = upd_q;
    err_r_d      = err_r_q;
    err_l_d      = err_l_q;
    lo_d         = lo_q;
    neg_d        = neg_q;
    sum_d        = sum_q;
    integ_r_d    = integ_r_q;
    integ_l_d    = integ_l_q;
    drv_r_d      = drv_r_q;
    drv_l_d      = drv_l_q;
    out_d        = out_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    mul_a        = '0;
    mul_b        = '0;
    div_start    = 1'b0;
    div_dividend = x[63] ? (64'd0 - x) : x;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          in_d    = in_item_i;
          since_d = since_sum[32] ? {32{1'b1}} : since_sum[31:0];
        end
      end
      S_HALF: begin
        mul_a = signed'({18'b0, track_q});
        mul_b = MulBW'(in_q.ang_ref);
      end
      S_SPLIT: begin
        err_r_d = 18'(in_q.lin_ref) + 18'(half) - 18'(in_q.meas_right);
        err_l_d = 18'(in_q.lin_ref) - 18'(half) - 18'(in_q.meas_left);
        upd_d   = due;
        wheel_d = 1'b0;
        if (due) begin
          dt_d    = since_q;
          since_d = '0;
        end
      end
      S_EDT: begin
        mul_a = signed'({2'b0, dt_q});
        mul_b = err_sel;
      end
      S_INTEG: begin
        // Saturate the integrator to its own signed range.
        if (isum[SumW-1:INTEG_WIDTH-1] != {(SumW - INTEG_WIDTH + 1){isum[SumW-1]}}) begin
          if (isum[SumW-1]) begin
            isum = signed'(SumW'({1'b1, {(INTEG_WIDTH - 1){1'b0}}}));
          end else begin
            isum = signed'(SumW'({1'b0, {(INTEG_WIDTH - 1){1'b1}}}));
          end
        end
        if (wheel_q) integ_l_d = isum[INTEG_WIDTH-1:0];
        else         integ_r_d = isum[INTEG_WIDTH-1:0];
      end
      S_ILO: begin
        mul_a = signed'({2'b0, integ_ext[31:0]});
        mul_b = signed'({2'b0, inv_q});
      end
      S_IHI: begin
        lo_d  = mul_p;
        mul_a = MulAW'(signed'(integ_ext[63:32]));
        mul_b = signed'({2'b0, inv_q});
      end
      S_IACC: begin
        // Divide the magnitude and restore the sign afterwards, which
        // gives truncation toward zero.
        neg_d     = x[63];
        div_start = 1'b1;
      end
      S_DIV: begin
        if (div_done) begin
          sum_d = 64'(err_sel) + (qs >>> GainFrac);
        end
      end
      S_GLO: begin
        mul_a = signed'({2'b0, sum_q[31:0]});
        mul_b = signed'({2'b0, gain_q});
      end
      S_GHI: begin
        lo_d  = mul_p;
        mul_a = MulAW'(signed'(sum_q[63:32]));
        mul_b = signed'({2'b0, gain_q});
      end
      S_GACC: begin
        if (wheel_q) drv_l_d = sat32_shifted(acc);
        else         drv_r_d = sat32_shifted(acc);
        wheel_d = 1'b1;
      end
      S_AVG: begin
        if (out_free) begin
          out_valid_d   = 1'b1;
          out_d.updated = upd_q;
          if (avg > lim_ext) begin
            out_d.drive   = lim_ext[16:0];
            out_d.clamped = 1'b1;
          end else if (avg < -lim_ext) begin
            out_d.drive   = 17'(-lim_ext);
            out_d.clamped = 1'b1;
          end else begin
            out_d.drive   = avg[16:0];
            out_d.clamped = 1'b0;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      wheel_q     <= 1'b0;
      since_q     <= '0;
      integ_r_q   <= '0;
      integ_l_q   <= '0;
      drv_r_q     <= '0;
      drv_l_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      wheel_q     <= wheel_d;
      since_q     <= since_d;
      integ_r_q   <= integ_r_d;
      integ_l_q   <= integ_l_d;
      drv_r_q     <= drv_r_d;
      drv_l_q     <= drv_l_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    in_q    <= in_d;
    dt_q    <= dt_d;
    upd_q   <= upd_d;
    err_r_q <= err_r_d;
    err_l_q <= err_l_d;
    lo_q    <= lo_d;
    neg_q   <= neg_d;
    sum_q   <= sum_d;
    out_q   <= out_d;
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

`ifndef SYNTH
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("input taken again right after an item was accepted");

  a_result_from_avg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == S_AVG))
    else $error("result appeared outside the averaging step");

  a_clamp_at_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_item_o.clamped) |->
      (out_item_o.drive == signed'({1'b0, lim_q})) ||
      (out_item_o.drive == -signed'({1'b0, lim_q})))
    else $error("clamped result is not at the drive limit");

  a_div_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV) |-> (div_busy || div_done))
    else $error("waiting on the divider while it is idle");
`endif

endmodule

`default_nettype wire
